// ===== design/bqssd_pkg.sv =====
package bqssd_pkg;

  localparam int HOLD_W     = 8;
  localparam int MAX_W      = 7;
  localparam int SHIFT_W    = 4;
  localparam int SPEED_W    = 8;
  localparam int CNT_W      = 8;
  localparam int PAT_W      = 4;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_SHIFT = 2'd2;

  localparam logic [HOLD_W-1:0]  HOLD_RESET  = 8'd2;
  localparam logic [MAX_W-1:0]   MAX_RESET   = 7'd127;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd8;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 8'hFF;

  typedef struct packed {
    logic sample;
    logic up;
    logic down;
  } btn_t;

  typedef struct packed {
    logic [HOLD_W-1:0]  hold;
    logic [MAX_W-1:0]   max_speed;
    logic [SHIFT_W-1:0] shift;
  } cfg_t;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic             stepped;
  } step_t;

endpackage

// ===== design/bqssd_if.sv =====
interface bqssd_in_if;
  logic valid;
  logic ready;
  logic sample;
  logic up_level;
  logic down_level;

  modport source (output valid, output sample, output up_level, output down_level,
                  input ready);
  modport sink (input valid, input sample, input up_level, input down_level,
                output ready);
endinterface

interface bqssd_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [bqssd_pkg::PAT_W-1:0]             coil_pattern;
  logic signed [bqssd_pkg::SPEED_W-1:0]    speed_value;
  logic                                    stepped;

  modport source (output valid, output coil_pattern, output speed_value, output stepped,
                  input ready);
  modport sink (input valid, input coil_pattern, input speed_value, input stepped,
                output ready);
endinterface

interface bqssd_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [bqssd_pkg::CFG_IDX_W-1:0]       index;
  logic [bqssd_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/bqssd_button.sv =====
module bqssd_button (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 fire,
  input  bqssd_pkg::cfg_t                      cfg,
  input  bqssd_pkg::btn_t                      btn,
  output logic signed [bqssd_pkg::SPEED_W-1:0] speed_next
);

  logic signed [bqssd_pkg::SPEED_W-1:0] speed;
  logic [bqssd_pkg::CNT_W-1:0]          up_count;
  logic [bqssd_pkg::CNT_W-1:0]          down_count;
  logic                                 released;

  logic [bqssd_pkg::CNT_W-1:0]          up_count_next;
  logic [bqssd_pkg::CNT_W-1:0]          down_count_next;
  logic                                 released_next;
  logic signed [bqssd_pkg::SPEED_W-1:0] limit;
  logic signed [bqssd_pkg::SPEED_W-1:0] neg_limit;

  assign limit     = $signed({1'b0, cfg.max_speed});
  assign neg_limit = -limit;

  always_comb begin
    up_count_next   = up_count;
    down_count_next = down_count;
    released_next   = released;
    speed_next      = speed;
    if (btn.sample) begin
      // Up wins when both buttons are held.
      if (btn.up) begin
        if (released && up_count != bqssd_pkg::CNT_MAX) begin
          up_count_next = up_count + 1'b1;
        end
      end else if (btn.down) begin
        if (released && down_count != bqssd_pkg::CNT_MAX) begin
          down_count_next = down_count + 1'b1;
        end
      end else begin
        released_next   = 1'b1;
        up_count_next   = '0;
        down_count_next = '0;
      end
      if (released_next) begin
        if (up_count_next > cfg.hold) begin
          if (speed < limit) begin
            speed_next = speed + bqssd_pkg::SPEED_W'(1);
          end
          up_count_next = '0;
          released_next = 1'b0;
        end else if (down_count_next > cfg.hold) begin
          if (speed > neg_limit) begin
            speed_next = speed - bqssd_pkg::SPEED_W'(1);
          end
          down_count_next = '0;
          released_next   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed      <= '0;
      up_count   <= '0;
      down_count <= '0;
      released   <= 1'b1;
    end else if (fire) begin
      speed      <= speed_next;
      up_count   <= up_count_next;
      down_count <= down_count_next;
      released   <= released_next;
    end
  end

`ifndef ASSERT_OFF
  // Both buttons seen low on a sample re-arms the latch and clears the counters.
  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && btn.sample && !btn.up && !btn.down)
      |=> (released && up_count == '0 && down_count == '0))
    else $error("release did not re-arm the button latch");

  // Speed moves by at most one per tick.
  a_speed_step: assert property (@(posedge clk) disable iff (rst)
    fire |=> (speed == $past(speed) || speed == $past(speed) + 1'sb1
              || speed == $past(speed) - 1'sb1))
    else $error("speed changed by more than one");
`endif

endmodule

// ===== design/bqssd_seq.sv =====
module bqssd_seq #(
  parameter int TIMER_WIDTH = 20
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 fire,
  input  logic [bqssd_pkg::SHIFT_W-1:0]        shift,
  input  logic signed [bqssd_pkg::SPEED_W-1:0] speed_next,
  output bqssd_pkg::step_t                     res
);

  localparam int RAW_W  = bqssd_pkg::SPEED_W + (2 ** bqssd_pkg::SHIFT_W) - 1;
  localparam int WIDE_W = (TIMER_WIDTH > RAW_W) ? TIMER_WIDTH : RAW_W;
  localparam logic [WIDE_W-1:0] TIMER_MAX = WIDE_W'({TIMER_WIDTH{1'b1}});

  logic [TIMER_WIDTH-1:0]            countdown;
  logic [bqssd_pkg::PHASE_W-1:0]     phase_index;
  logic [bqssd_pkg::PAT_W-1:0]       pattern_hold;

  logic [TIMER_WIDTH-1:0]            countdown_dec;
  logic [TIMER_WIDTH-1:0]            countdown_next;
  logic [TIMER_WIDTH-1:0]            period;
  logic [WIDE_W-1:0]                 period_wide;
  logic [bqssd_pkg::SPEED_W-1:0]     mag;
  logic [bqssd_pkg::PHASE_W-1:0]     phase_inc;
  logic [bqssd_pkg::PHASE_W-1:0]     phase_next;
  logic [bqssd_pkg::PAT_W-1:0]       pattern_new;
  logic                              step;

  assign countdown_dec = (countdown != '0) ? countdown - 1'b1 : countdown;
  assign step          = (countdown_dec == '0) && (speed_next != '0);

  assign mag         = speed_next[bqssd_pkg::SPEED_W-1] ? bqssd_pkg::SPEED_W'(-speed_next)
                                                        : bqssd_pkg::SPEED_W'(speed_next);
  assign period_wide = WIDE_W'(mag) << shift;
  assign period      = (period_wide > TIMER_MAX) ? TIMER_WIDTH'(TIMER_MAX)
                                                 : TIMER_WIDTH'(period_wide);

  // Two adjacent coils on, wrapping from coil three back to coil zero.
  assign phase_inc   = bqssd_pkg::PHASE_W'(phase_index + 1'b1);
  assign pattern_new = (bqssd_pkg::PAT_W'(1) << phase_index)
                     | (bqssd_pkg::PAT_W'(1) << phase_inc);
  assign phase_next  = speed_next[bqssd_pkg::SPEED_W-1]
                     ? bqssd_pkg::PHASE_W'(phase_index - 1'b1) : phase_inc;

  assign countdown_next = step ? period : countdown_dec;

  assign res.pattern = step ? pattern_new : pattern_hold;
  assign res.stepped = step;

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown    <= '0;
      phase_index  <= '0;
      pattern_hold <= '0;
    end else if (fire) begin
      countdown <= countdown_next;
      if (step) begin
        phase_index  <= phase_next;
        pattern_hold <= pattern_new;
      end
    end
  end

`ifndef ASSERT_OFF
  // A step always reloads a nonzero period, since its magnitude is at least one.
  a_step_reload: assert property (@(posedge clk) disable iff (rst)
    (fire && step) |=> (countdown != '0))
    else $error("step left the countdown at zero");
`endif

endmodule

// ===== design/button_qualified_stepper_speed_drive.sv =====
// Button-qualified speed setting with a full-step stepper sequencer, one channel.
// in_ch carries one base tick per beat: sample, up_level and down_level. out_ch
// returns exactly one beat per tick: coil_pattern, speed_value (after this tick's
// button update) and stepped. cfg writes hold_samples (index 0), max_speed
// (index 1) and period_shift (index 2); it is always ready and should only be
// used while no tick is in flight. Writes to index 3 are ignored.
// A tick accepted into the input stage moves on into the output register, and
// out_ch presents its result beat from there. Throughput is one tick per cycle
// while out_ch is ready: the whole update is a single pass of logic between the
// input stage and the output register, with the state written as the tick moves to the output.
// When out_ch stalls the output register holds its beat and the input stage
// keeps one more tick, so in_ch stays ready until both are full.
// Reset (rst, synchronous) empties both stages, sets speed, counters, phase,
// countdown and coil pattern to zero, re-arms the release latch, and loads the
// registers with hold_samples 2, max_speed 127 and period_shift 8.
// Step periods saturate at 2**TIMER_WIDTH - 1 ticks.
module button_qualified_stepper_speed_drive #(
  parameter int TIMER_WIDTH = 20
) (
  input  logic         clk,
  input  logic         rst,
  bqssd_in_if.sink     in_ch,
  bqssd_out_if.source  out_ch,
  bqssd_cfg_if.sink    cfg
);

  bqssd_pkg::cfg_t                      cfg_regs;
  bqssd_pkg::btn_t                      stage_btn;
  logic                                 stage_valid;
  logic                                 out_valid;
  logic [bqssd_pkg::PAT_W-1:0]          out_pattern;
  logic signed [bqssd_pkg::SPEED_W-1:0] out_speed;
  logic                                 out_stepped;

  logic                                 fire;
  logic signed [bqssd_pkg::SPEED_W-1:0] speed_next;
  bqssd_pkg::step_t                     step_res;

  assign fire        = stage_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !stage_valid || fire;
  assign cfg.ready   = 1'b1;

  assign out_ch.valid        = out_valid;
  assign out_ch.coil_pattern = out_pattern;
  assign out_ch.speed_value  = out_speed;
  assign out_ch.stepped      = out_stepped;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.hold      <= bqssd_pkg::HOLD_RESET;
      cfg_regs.max_speed <= bqssd_pkg::MAX_RESET;
      cfg_regs.shift     <= bqssd_pkg::SHIFT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bqssd_pkg::CFG_HOLD_SAMPLES: cfg_regs.hold      <= cfg.data;
        bqssd_pkg::CFG_MAX_SPEED:    cfg_regs.max_speed <= cfg.data[bqssd_pkg::MAX_W-1:0];
        bqssd_pkg::CFG_PERIOD_SHIFT: cfg_regs.shift     <= cfg.data[bqssd_pkg::SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      stage_btn.sample <= in_ch.sample;
      stage_btn.up     <= in_ch.up_level;
      stage_btn.down   <= in_ch.down_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      out_pattern <= step_res.pattern;
      out_speed   <= speed_next;
      out_stepped <= step_res.stepped;
    end
  end

  bqssd_button u_button (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .cfg        (cfg_regs),
    .btn        (stage_btn),
    .speed_next (speed_next)
  );

  bqssd_seq #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .shift      (cfg_regs.shift),
    .speed_next (speed_next),
    .res        (step_res)
  );

`ifndef ASSERT_OFF
  // With both stages full and the output stalled, no new tick may enter.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && out_valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted with both stages full");

  // A result beat that reports a step shows exactly two coils on.
  a_two_coils: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stepped) |-> ($countones(out_pattern) == 2))
    else $error("step pattern does not have two coils on");
`endif

endmodule

// ===== sim/tb_button_qualified_stepper_speed_drive.sv =====
module tb_button_qualified_stepper_speed_drive;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMER_W = 20;
  localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_W) - 64'd1;
  localparam int IDLE_LIMIT = 2000;
  // Index 3 is not a register; writes there must leave everything alone.
  localparam logic [bqssd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [12:0] RX_PATTERN = 13'b1011011101101;

  typedef struct packed {
    logic [bqssd_pkg::PAT_W-1:0]          coil;
    logic signed [bqssd_pkg::SPEED_W-1:0] speed;
    logic                                 stepped;
  } drive_beat_t;

  logic clk;
  logic rst;

  bqssd_in_if  in_ch();
  bqssd_out_if out_ch();
  bqssd_cfg_if cfg_ch();

  button_qualified_stepper_speed_drive #(
    .TIMER_WIDTH(TIMER_W)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg   (cfg_ch)
  );

  // Predicted state of the drive and its registers.
  logic [bqssd_pkg::HOLD_W-1:0]  hold_q  = bqssd_pkg::HOLD_RESET;
  logic [bqssd_pkg::MAX_W-1:0]   max_q   = bqssd_pkg::MAX_RESET;
  logic [bqssd_pkg::SHIFT_W-1:0] shift_q = bqssd_pkg::SHIFT_RESET;
  int                            spd = 0;
  logic [bqssd_pkg::CNT_W-1:0]   up_cnt = '0;
  logic [bqssd_pkg::CNT_W-1:0]   dn_cnt = '0;
  logic                          rel_latch = 1'b1;
  logic [bqssd_pkg::PHASE_W-1:0] phase = '0;
  longint unsigned               step_cd = 0;
  logic [bqssd_pkg::PAT_W-1:0]   coil = '0;

  drive_beat_t expected_drive[$];

  int errors = 0;
  int ticks_sent = 0;
  int beats_checked = 0;
  int steps_seen = 0;
  int reg_writes = 0;
  int spd_hi = 0;
  int spd_lo = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int rx_hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic drive_beat_t drive_tick(input logic smp, input logic up,
                                             input logic dn);
    drive_beat_t beat;
    longint unsigned period;
    logic [bqssd_pkg::PHASE_W-1:0] nxt;
    beat.stepped = 1'b0;
    if (smp) begin
      if (up) begin
        if (rel_latch && up_cnt != bqssd_pkg::CNT_MAX) up_cnt++;
      end else if (dn) begin
        if (rel_latch && dn_cnt != bqssd_pkg::CNT_MAX) dn_cnt++;
      end else begin
        rel_latch = 1'b1;
        up_cnt = '0;
        dn_cnt = '0;
      end
      if (rel_latch) begin
        if (up_cnt > hold_q) begin
          if (spd < int'(max_q)) spd++;
          up_cnt = '0;
          rel_latch = 1'b0;
        end else if (dn_cnt > hold_q) begin
          if (spd > -int'(max_q)) spd--;
          dn_cnt = '0;
          rel_latch = 1'b0;
        end
      end
    end
    if (step_cd != 0) step_cd--;
    if (step_cd == 0 && spd != 0) begin
      nxt = phase + 2'd1;
      coil = (bqssd_pkg::PAT_W'(1) << phase) | (bqssd_pkg::PAT_W'(1) << nxt);
      phase = (spd > 0) ? nxt : phase - 2'd1;
      period = longint'(spd < 0 ? -spd : spd);
      period = period << shift_q;
      if (period > TIMER_MAX) period = TIMER_MAX;
      step_cd = period;
      beat.stepped = 1'b1;
      steps_seen++;
    end
    if (spd > spd_hi) spd_hi = spd;
    if (spd < spd_lo) spd_lo = spd;
    beat.coil = coil;
    beat.speed = bqssd_pkg::SPEED_W'(spd);
    return beat;
  endfunction

  // Predicts at each accepted tick and checks each accepted result beat.
  always @(posedge clk) begin
    drive_beat_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        reg_writes++;
        case (cfg_ch.index)
          bqssd_pkg::CFG_HOLD_SAMPLES: hold_q  = cfg_ch.data[bqssd_pkg::HOLD_W-1:0];
          bqssd_pkg::CFG_MAX_SPEED:    max_q   = cfg_ch.data[bqssd_pkg::MAX_W-1:0];
          bqssd_pkg::CFG_PERIOD_SHIFT: shift_q = cfg_ch.data[bqssd_pkg::SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_drive.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected", $time);
        end else begin
          want = expected_drive.pop_front();
          beats_checked++;
          if (out_ch.coil_pattern !== want.coil) begin
            errors++;
            $display("%0t: coil_pattern expected %b got %b", $time, want.coil,
                     out_ch.coil_pattern);
          end
          if (out_ch.speed_value !== want.speed) begin
            errors++;
            $display("%0t: speed_value expected %0d got %0d", $time, want.speed,
                     out_ch.speed_value);
          end
          if (out_ch.stepped !== want.stepped) begin
            errors++;
            $display("%0t: stepped expected %b got %b", $time, want.stepped,
                     out_ch.stepped);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_drive.push_back(drive_tick(in_ch.sample, in_ch.up_level,
                                            in_ch.down_level));
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
          $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // Result side: switches between always ready, random stalls and a fixed
  // stall pattern, and honours a requested long hold-off.
  initial begin
    int mode;
    int mode_left;
    int hold_cnt;
    int pat_pos;
    mode = 0;
    mode_left = 0;
    hold_cnt = 0;
    pat_pos = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_cnt = rx_hold_req;
        rx_hold_req = 0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      pat_pos = (pat_pos == 12) ? 0 : pat_pos + 1;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= RX_PATTERN[pat_pos];
        endcase
      end
    end
  end

  // Sends one tick; the sender runs in bursts with random gaps between them.
  task automatic send_tick(input logic smp, input logic up, input logic dn);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.sample     <= smp;
    in_ch.up_level   <= up;
    in_ch.down_level <= dn;
    ticks_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Holds a button for a number of sample ticks, then releases it.
  task automatic press_button(input logic up, input logic dn, input int samples);
    repeat (samples) send_tick(1'b1, up, dn);
    send_tick(1'b1, 1'b0, 1'b0);
  endtask

  // Stops sending and waits until every expected beat has come back.
  task automatic drain_all();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [bqssd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bqssd_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input int hold, input int max_spd, input int shift);
    drain_all();
    cfg_write(bqssd_pkg::CFG_HOLD_SAMPLES, bqssd_pkg::CFG_DATA_W'(hold));
    cfg_write(bqssd_pkg::CFG_MAX_SPEED, bqssd_pkg::CFG_DATA_W'(max_spd));
    cfg_write(bqssd_pkg::CFG_PERIOD_SHIFT, bqssd_pkg::CFG_DATA_W'(shift));
  endtask

  task automatic test_reset_state();
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
  endtask

  // Reset register values: a press needs three samples and the step period is
  // speed times 256.
  task automatic test_press_defaults();
    press_button(1'b1, 1'b0, 2);
    press_button(1'b1, 1'b0, 6);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    press_button(1'b1, 1'b1, 3);
    press_button(1'b0, 1'b1, 3);
    press_button(1'b0, 1'b1, 3);
    // At zero speed the countdown keeps running down to zero.
    while (step_cd != 0) send_tick(1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_phase_rotation();
    set_regs(0, 127, 0);
    press_button(1'b1, 1'b0, 1);
    repeat (6) send_tick(1'b1, 1'b0, 1'b0);
    press_button(1'b0, 1'b1, 1);
    press_button(1'b0, 1'b1, 1);
    repeat (6) send_tick(1'b0, 1'b0, 1'b0);
    press_button(1'b1, 1'b0, 1);
  endtask

  task automatic test_speed_limits();
    set_regs(0, 2, 0);
    repeat (4) press_button(1'b1, 1'b0, 1);
    repeat (6) press_button(1'b0, 1'b1, 1);
    drain_all();
    cfg_write(bqssd_pkg::CFG_MAX_SPEED, bqssd_pkg::CFG_DATA_W'(1));
    cfg_write(CFG_SPARE, 8'hFF);
    press_button(1'b0, 1'b1, 1);
    press_button(1'b1, 1'b0, 1);
    drain_all();
    cfg_write(bqssd_pkg::CFG_MAX_SPEED, bqssd_pkg::CFG_DATA_W'(0));
    repeat (2) press_button(1'b1, 1'b0, 1);
    press_button(1'b0, 1'b1, 1);
  endtask

  // With hold_samples at 255 the saturated counter can never exceed it.
  task automatic test_counter_saturation();
    set_regs(255, 127, 0);
    press_button(1'b1, 1'b0, 257);
  endtask

  // Runs the speed up to its positive limit and presses on past it.
  task automatic test_speed_extremes();
    set_regs(0, 127, 0);
    repeat (129) press_button(1'b1, 1'b0, 1);
  endtask

  task automatic test_backpressure();
    set_regs(1, 5, 1);
    rx_hold_req = 60;
    repeat (24) send_tick(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    drain_all();
  endtask

  // Mostly well-formed presses with random content, some cut short or left
  // unreleased, and some pure noise.
  task automatic test_random_presses();
    int start;
    int sel;
    int n;
    logic up;
    logic dn;
    for (int ph = 0; ph < 3; ph++) begin
      set_regs(($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3),
               ($urandom_range(0, 4) == 0) ? 127 : $urandom_range(1, 8),
               $urandom_range(0, 3));
      start = ticks_sent;
      while (ticks_sent - start < 96) begin
        if ($urandom_range(0, 9) < 8) begin
          sel = $urandom_range(0, 4);
          up = (sel < 2) || (sel == 4);
          dn = (sel >= 2);
          n = int'(hold_q) + 1 + $urandom_range(0, 2);
          if ($urandom_range(0, 4) == 0) n = n - 1;
          repeat (n) begin
            if ($urandom_range(0, 3) == 0)
              send_tick(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            send_tick(1'b1, up, dn);
          end
          if ($urandom_range(0, 7) != 0) send_tick(1'b1, 1'b0, 1'b0);
        end else begin
          repeat ($urandom_range(1, 4))
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  task automatic test_long_period();
    set_regs(0, 127, 12);
    repeat (2) press_button(1'b1, 1'b0, 1);
    repeat (20) send_tick(1'b1, 1'b0, 1'b0);
  endtask

  initial begin
    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.sample     <= 1'b0;
    in_ch.up_level   <= 1'b0;
    in_ch.down_level <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= bqssd_pkg::CFG_HOLD_SAMPLES;
    cfg_ch.data      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_press_defaults();
    test_phase_rotation();
    test_speed_limits();
    test_counter_saturation();
    test_speed_extremes();
    test_backpressure();
    test_random_presses();
    test_long_period();
    drain_all();

    if (expected_drive.size() != 0) begin
      errors++;
      $display("%0t: %0d result beats never arrived", $time, expected_drive.size());
    end
    $display("Checked %0d ticks with %0d steps and %0d register writes.", beats_checked,
             steps_seen, reg_writes);
    $display("Speed went from %0d to %0d; %0d mismatches.", spd_lo, spd_hi, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== button_qualified_stepper_speed_drive.f =====
design/bqssd_pkg.sv
design/bqssd_if.sv
design/bqssd_button.sv
design/bqssd_seq.sv
design/button_qualified_stepper_speed_drive.sv
sim/tb_button_qualified_stepper_speed_drive.sv
